/* hw/rtl/pbmt_pkg.sv */
// Shared types and constants for the binomial coefficient table core.
`default_nettype none

package pbmt_pkg;

  // Field widths of the stream beats
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned VAL_W       = 30;
  localparam int unsigned SUM_W       = VAL_W + 1;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned QADDR_W     = 12;

  // Modulus after reset
  localparam logic [VAL_W-1:0] MODULUS_RESET = 30'd1000000007;

  // Command codes carried on the input tuser
  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Status codes carried on the output tuser
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_BUILT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QREAD,
    ST_BSTEP,
    ST_BSUM,
    ST_BDONE
  } state_e;

endpackage

`default_nettype wire

/* hw/rtl/pascal_binomial_mod_table_core.sv */
// Binomial coefficient table modulo a programmable modulus, built by Pascal's rule.
//
// Input beats on s_axis_*: tuser selects build (0) or query (1); tdata carries
// n (bits 5:0) and k (bits 11:6), both ignored on a build. Each input beat yields
// one output beat on m_axis_*: value in tdata[29:0], status in tuser (1 = not built).
// A build returns 0 with status ok. A query returns C(n,k) mod modulus, 0 for k > n
// or n >= ROWS, and 0 with status not-built before the first build.
// Write the modulus through cfg_wen_i / cfg_wdata_i only while the core is idle.
// Timing: one beat is in work at a time and s_axis_tready is high only when idle.
// A query result passes through the registered table read and then the output register.
// A build walks the triangle with the shared add and conditional subtract unit:
// an interior entry reads the two entries above (ST_BSTEP), then sums and writes
// back (ST_BSUM); an edge entry is written in ST_BSTEP; ST_BDONE posts the result.
// Reset clears the control state and the built flag and restores the modulus;
// the table memory is not cleared. A stalled receiver holds the output beat; a
// new result waits in ST_QREAD or ST_BDONE until the held beat is taken, and the
// core returns to idle once its result is registered.
`default_nettype none

module pascal_binomial_mod_table_core #(
  parameter int unsigned ROWS = 64
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // Configuration: modulus register
  input  wire logic                                   cfg_wen_i,
  input  wire logic [pbmt_pkg::VAL_W-1:0]             cfg_wdata_i,
  // Input stream
  input  wire logic                                   s_axis_tvalid,
  output      logic                                   s_axis_tready,
  input  wire logic [pbmt_pkg::IN_TDATA_W-1:0]        s_axis_tdata,  // row_n[5:0], col_k[11:6]
  input  wire logic                                   s_axis_tuser,  // opcode[0]
  // Output stream
  output      logic                                   m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  output      logic [pbmt_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,  // value[29:0]
  output      logic                                   m_axis_tuser   // status[0]
);

  localparam int unsigned TABLE_SIZE = ROWS * (ROWS + 1) / 2;
  localparam int unsigned AW         = $clog2(TABLE_SIZE);
  localparam int unsigned NW         = $clog2(ROWS);
  localparam logic [NW-1:0] LAST_ROW = NW'(ROWS - 1);

  // Triangular coefficient store: entry (n,k) sits at n*(n+1)/2 + k
  logic [pbmt_pkg::VAL_W-1:0] coeff_mem [TABLE_SIZE];

  pbmt_pkg::state_e state_q, state_d;

  logic [pbmt_pkg::VAL_W-1:0] modulus_q;
  logic                       built_q, built_d;
  logic [NW-1:0]              n_q, n_d, k_q, k_d;
  logic [AW-1:0]              base_q, base_d, pbase_q, pbase_d;
  logic                       q_ok_q, q_ok_d, q_nb_q, q_nb_d;

  logic                       out_valid_q, out_valid_d;
  logic [pbmt_pkg::VAL_W-1:0] out_value_q, out_value_d;
  logic                       out_status_q, out_status_d;

  // Memory ports
  logic                       mem_we;
  logic [AW-1:0]              mem_wa;
  logic [pbmt_pkg::VAL_W-1:0] mem_wd;
  logic                       re_a, re_b;
  logic [AW-1:0]              ra_a, ra_b;
  logic [pbmt_pkg::VAL_W-1:0] rd_a_q, rd_b_q;

  // Input beat fields
  logic [pbmt_pkg::IDX_W-1:0] in_n, in_k;
  logic                       in_op;
  logic                       in_fire, out_free;

  // Query address computation
  logic [pbmt_pkg::IDX_W:0]     q_np1;
  logic [2*pbmt_pkg::IDX_W:0]   q_prod;
  logic [pbmt_pkg::QADDR_W-1:0] q_addr;
  logic                         q_in_range;

  // Shared add and conditional subtract unit
  logic [pbmt_pkg::SUM_W-1:0] sum_raw;
  logic [pbmt_pkg::VAL_W-1:0] sum_mod;
  logic [pbmt_pkg::VAL_W-1:0] edge_val;
  logic                       row_end, last_entry;

  assign in_n  = s_axis_tdata[pbmt_pkg::IDX_W-1:0];
  assign in_k  = s_axis_tdata[2*pbmt_pkg::IDX_W-1:pbmt_pkg::IDX_W];
  assign in_op = s_axis_tuser;

  assign s_axis_tready = (state_q == pbmt_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign q_np1      = {1'b0, in_n} + 1'b1;
  assign q_prod     = (2*pbmt_pkg::IDX_W+1)'(in_n) * (2*pbmt_pkg::IDX_W+1)'(q_np1);
  assign q_addr     = pbmt_pkg::QADDR_W'(q_prod >> 1) + pbmt_pkg::QADDR_W'(in_k);
  assign q_in_range = (in_k <= in_n) && (32'(in_n) < ROWS);

  assign sum_raw  = pbmt_pkg::SUM_W'(rd_a_q) + pbmt_pkg::SUM_W'(rd_b_q);
  assign sum_mod  = (sum_raw >= pbmt_pkg::SUM_W'(modulus_q))
                  ? pbmt_pkg::VAL_W'(sum_raw - pbmt_pkg::SUM_W'(modulus_q))
                  : pbmt_pkg::VAL_W'(sum_raw);
  // Every residue modulo one (or a zero modulus) is zero
  assign edge_val = (modulus_q < pbmt_pkg::VAL_W'(2)) ? '0 : pbmt_pkg::VAL_W'(1);

  assign row_end    = (k_q == n_q);
  assign last_entry = row_end && (n_q == LAST_ROW);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pbmt_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = (in_op == pbmt_pkg::OP_BUILD) ? pbmt_pkg::ST_BSTEP : pbmt_pkg::ST_QREAD;
        end
      end
      pbmt_pkg::ST_QREAD: begin
        if (out_free) begin
          state_d = pbmt_pkg::ST_IDLE;
        end
      end
      pbmt_pkg::ST_BSTEP: begin
        if (k_q == '0 || row_end) begin
          state_d = last_entry ? pbmt_pkg::ST_BDONE : pbmt_pkg::ST_BSTEP;
        end else begin
          state_d = pbmt_pkg::ST_BSUM;
        end
      end
      pbmt_pkg::ST_BSUM: begin
        state_d = pbmt_pkg::ST_BSTEP;
      end
      pbmt_pkg::ST_BDONE: begin
        if (out_free) begin
          state_d = pbmt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pbmt_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath control
  always_comb begin
    n_d          = n_q;
    k_d          = k_q;
    base_d       = base_q;
    pbase_d      = pbase_q;
    built_d      = built_q;
    q_ok_d       = q_ok_q;
    q_nb_d       = q_nb_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    mem_we       = 1'b0;
    mem_wa       = base_q + AW'(k_q);
    mem_wd       = edge_val;
    re_a         = 1'b0;
    re_b         = 1'b0;
    ra_a         = pbase_q + AW'(k_q) - AW'(1);
    ra_b         = pbase_q + AW'(k_q);

    case (state_q)
      pbmt_pkg::ST_IDLE: begin
        n_d     = '0;
        k_d     = '0;
        base_d  = '0;
        pbase_d = '0;
        if (in_fire && in_op == pbmt_pkg::OP_QUERY) begin
          q_ok_d = built_q && q_in_range;
          q_nb_d = !built_q;
          re_a   = built_q && q_in_range;
          ra_a   = AW'(q_addr);
        end
      end
      pbmt_pkg::ST_QREAD: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = q_ok_q ? rd_a_q : '0;
          out_status_d = q_nb_q ? pbmt_pkg::STATUS_NOT_BUILT : pbmt_pkg::STATUS_OK;
        end
      end
      pbmt_pkg::ST_BSTEP: begin
        if (k_q == '0 || row_end) begin
          mem_we = 1'b1;
          mem_wd = edge_val;
        end else begin
          // Fetch the two entries above from the previous row
          re_a = 1'b1;
          re_b = 1'b1;
        end
      end
      pbmt_pkg::ST_BSUM: begin
        mem_we = 1'b1;
        mem_wd = sum_mod;
      end
      pbmt_pkg::ST_BDONE: begin
        if (out_free) begin
          built_d      = 1'b1;
          out_valid_d  = 1'b1;
          out_value_d  = '0;
          out_status_d = pbmt_pkg::STATUS_OK;
        end
      end
      default: begin
      end
    endcase

    // Advance the triangle walk after each entry written
    if (mem_we) begin
      if (row_end) begin
        if (!last_entry) begin
          n_d     = n_q + NW'(1);
          k_d     = '0;
          pbase_d = base_q;
          base_d  = base_q + AW'(n_q) + AW'(1);
        end
      end else begin
        k_d = k_q + NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pbmt_pkg::ST_IDLE;
      modulus_q   <= pbmt_pkg::MODULUS_RESET;
      built_q     <= 1'b0;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      k_q         <= '0;
      base_q      <= '0;
      pbase_q     <= '0;
      q_ok_q      <= 1'b0;
      q_nb_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      built_q     <= built_d;
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
      k_q         <= k_d;
      base_q      <= base_d;
      pbase_q     <= pbase_d;
      q_ok_q      <= q_ok_d;
      q_nb_q      <= q_nb_d;
      if (cfg_wen_i) begin
        modulus_q <= cfg_wdata_i;
      end
    end
  end

  // Output payload needs no reset
  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  // Table memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      coeff_mem[mem_wa] <= mem_wd;
    end
    if (re_a) begin
      rd_a_q <= coeff_mem[ra_a];
    end
    if (re_b) begin
      rd_b_q <= coeff_mem[ra_b];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = pbmt_pkg::OUT_TDATA_W'(out_value_q);
  assign m_axis_tuser  = out_status_q;

endmodule

`default_nettype wire

/* hw/rtl/pbmt_checker.sv */
// Port-level assertions for the binomial coefficient table core, bound to the top level.
`default_nettype none

module pbmt_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                s_axis_tvalid,
  input wire logic                                s_axis_tready,
  input wire logic                                s_axis_tuser,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  input wire logic [pbmt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input wire logic                                m_axis_tuser
);

  // Hold a stalled output beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // One beat in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a beat is in work");

  // A build walks the whole triangle, so input stays blocked while it runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == pbmt_pkg::OP_BUILD |=>
      ##1 !s_axis_tready)
    else $error("build finished too early");

  // A not-built status always carries a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == pbmt_pkg::STATUS_NOT_BUILT |-> m_axis_tdata == '0)
    else $error("not-built beat with nonzero value");

endmodule

bind pascal_binomial_mod_table_core pbmt_checker u_pbmt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

/* test/pascal_binomial_mod_table_core_test.sv */
`timescale 1ns / 1ps
// Self-checking stream testbench for the Pascal binomial coefficient table core.
module pascal_binomial_mod_table_core_test;
  import pbmt_pkg::*;

  localparam int unsigned ROWS           = 64;
  localparam int unsigned TRI_SIZE       = ROWS * (ROWS + 1) / 2;
  localparam int unsigned RANDOM_ITEMS   = 1300;
  // A build keeps the input side busy for a whole triangle walk with no beat moving.
  localparam int unsigned WATCHDOG_LIMIT = 40000;
  localparam int unsigned MAX_REPORTS    = 40;
  localparam logic [VAL_W-1:0] MODULUS_MAX = '1;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             status;
  } coeff_beat_t;

  typedef enum logic {ROW_BEAT, ROW_MODULUS} row_kind_e;

  // One directed step: either a beat to send or a modulus to program (value field).
  typedef struct packed {
    row_kind_e        kind;
    logic             op;
    logic [IDX_W-1:0] n;
    logic [IDX_W-1:0] k;
    logic             typed;
    logic [VAL_W-1:0] value;
    logic             status;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [27] = '{
    // queries refused before the first build
    '{ROW_BEAT,    OP_QUERY, 6'd0,  6'd0,  1'b1, 30'd0,   STATUS_NOT_BUILT},
    '{ROW_BEAT,    OP_QUERY, 6'd63, 6'd63, 1'b1, 30'd0,   STATUS_NOT_BUILT},
    '{ROW_BEAT,    OP_QUERY, 6'd0,  6'd63, 1'b1, 30'd0,   STATUS_NOT_BUILT},
    // build under the reset modulus, then edges, diagonal and k above n
    '{ROW_BEAT,    OP_BUILD, 6'd0,  6'd0,  1'b1, 30'd0,   STATUS_OK},
    '{ROW_BEAT,    OP_QUERY, 6'd0,  6'd0,  1'b1, 30'd1,   STATUS_OK},
    '{ROW_BEAT,    OP_QUERY, 6'd63, 6'd0,  1'b1, 30'd1,   STATUS_OK},
    '{ROW_BEAT,    OP_QUERY, 6'd63, 6'd63, 1'b1, 30'd1,   STATUS_OK},
    '{ROW_BEAT,    OP_QUERY, 6'd0,  6'd63, 1'b1, 30'd0,   STATUS_OK},
    '{ROW_BEAT,    OP_QUERY, 6'd62, 6'd63, 1'b1, 30'd0,   STATUS_OK},
    '{ROW_BEAT,    OP_QUERY, 6'd10, 6'd5,  1'b1, 30'd252, STATUS_OK},
    '{ROW_BEAT,    OP_QUERY, 6'd63, 6'd1,  1'b1, 30'd63,  STATUS_OK},
    '{ROW_BEAT,    OP_QUERY, 6'd63, 6'd31, 1'b0, 30'd0,   STATUS_OK},
    // new modulus: the stored table keeps its old residues until rebuilt
    '{ROW_MODULUS, OP_BUILD, 6'd0,  6'd0,  1'b0, 30'd2,   STATUS_OK},
    '{ROW_BEAT,    OP_QUERY, 6'd63, 6'd31, 1'b0, 30'd0,   STATUS_OK},
    '{ROW_BEAT,    OP_BUILD, 6'd63, 6'd63, 1'b1, 30'd0,   STATUS_OK},
    '{ROW_BEAT,    OP_QUERY, 6'd63, 6'd31, 1'b0, 30'd0,   STATUS_OK},
    '{ROW_BEAT,    OP_BUILD, 6'd17, 6'd42, 1'b1, 30'd0,   STATUS_OK},
    // modulus one and zero fill the table with zeros
    '{ROW_MODULUS, OP_BUILD, 6'd0,  6'd0,  1'b0, 30'd1,   STATUS_OK},
    '{ROW_BEAT,    OP_BUILD, 6'd0,  6'd0,  1'b1, 30'd0,   STATUS_OK},
    '{ROW_BEAT,    OP_QUERY, 6'd0,  6'd0,  1'b1, 30'd0,   STATUS_OK},
    '{ROW_MODULUS, OP_BUILD, 6'd0,  6'd0,  1'b0, 30'd0,   STATUS_OK},
    '{ROW_BEAT,    OP_BUILD, 6'd0,  6'd0,  1'b1, 30'd0,   STATUS_OK},
    '{ROW_BEAT,    OP_QUERY, 6'd63, 6'd63, 1'b1, 30'd0,   STATUS_OK},
    // largest modulus
    '{ROW_MODULUS, OP_BUILD, 6'd0,  6'd0,  1'b0, 30'h3FFFFFFF, STATUS_OK},
    '{ROW_BEAT,    OP_BUILD, 6'd0,  6'd0,  1'b1, 30'd0,   STATUS_OK},
    '{ROW_BEAT,    OP_QUERY, 6'd63, 6'd32, 1'b0, 30'd0,   STATUS_OK},
    '{ROW_BEAT,    OP_QUERY, 6'd40, 6'd20, 1'b0, 30'd0,   STATUS_OK}
  };

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_wen_i     = 1'b0;
  logic [VAL_W-1:0]       cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  // Predictor state: its own copy of the triangle, the modulus and the built flag
  logic [VAL_W-1:0] coeff_model [TRI_SIZE];
  logic [VAL_W-1:0] model_modulus;
  logic             model_built;

  coeff_beat_t      expected_coeffs [$];
  coeff_beat_t      beat_typed_result;
  logic             beat_typed   = 1'b0;
  int unsigned      fail_count   = 0;
  int unsigned      idle_cycles  = 0;
  int unsigned      burst_left   = 0;
  int unsigned      stall_mode   = 0;
  int unsigned      stall_left   = 0;

  pascal_binomial_mod_table_core #(
    .ROWS(ROWS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wen_i    (cfg_wen_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Work out the result beat of one command and advance the predictor state.
  function automatic coeff_beat_t predict_coeff(input logic op, input logic [IDX_W-1:0] n,
                                                input logic [IDX_W-1:0] k);
    coeff_beat_t      res;
    logic [SUM_W-1:0] sum;
    int unsigned      row, col, row_base, prev_base, nn, kk;
    res.value  = '0;
    res.status = STATUS_OK;
    nn = n;
    kk = k;
    if (op == OP_BUILD) begin
      for (row = 0; row < ROWS; row++) begin
        row_base  = row * (row + 1) / 2;
        prev_base = row_base - row;
        for (col = 0; col <= row; col++) begin
          if (model_modulus < 2) begin
            coeff_model[row_base + col] = '0;
          end else if (col == 0 || col == row) begin
            coeff_model[row_base + col] = VAL_W'(1);
          end else begin
            // Pascal's rule, reduced by a single conditional subtract
            sum = {1'b0, coeff_model[prev_base + col]} + {1'b0, coeff_model[prev_base + col - 1]};
            if (sum >= {1'b0, model_modulus}) sum = sum - {1'b0, model_modulus};
            coeff_model[row_base + col] = sum[VAL_W-1:0];
          end
        end
      end
      model_built = 1'b1;
    end else if (!model_built) begin
      res.status = STATUS_NOT_BUILT;
    end else if (kk <= nn && nn < ROWS) begin
      res.value = coeff_model[nn * (nn + 1) / 2 + kk];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_TDATA_W-1:0] want,
                                 input logic [OUT_TDATA_W-1:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
  endtask

  // Present one command beat and hold it until the core takes it.
  task automatic send_beat(input logic op, input logic [IDX_W-1:0] n,
                           input logic [IDX_W-1:0] k, input logic typed,
                           input coeff_beat_t typed_result);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid     <= 1'b1;
    s_axis_tdata      <= {{(IN_TDATA_W - 2*IDX_W){1'b0}}, k, n};
    s_axis_tuser      <= op;
    beat_typed        = typed;
    beat_typed_result = typed_result;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Program the modulus once every result is back, i.e. with the core idle.
  task automatic write_modulus(input logic [VAL_W-1:0] modulus);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_coeffs.size() != 0) @(negedge clk_i);
    cfg_wen_i     <= 1'b1;
    cfg_wdata_i   <= modulus;
    model_modulus = modulus;
    @(negedge clk_i);
    cfg_wen_i <= 1'b0;
  endtask

  // Receiver: switch between always ready, coin flip and mostly stalled.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(8, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Check result beats against the oldest expectation, then log new commands.
  always @(posedge clk_i) begin : scoreboard
    coeff_beat_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_coeffs.size() == 0) begin
          report_mismatch("unexpected result beat", '0, m_axis_tdata);
        end else begin
          want = expected_coeffs.pop_front();
          if (m_axis_tdata !== {{(OUT_TDATA_W - VAL_W){1'b0}}, want.value})
            report_mismatch("value", {{(OUT_TDATA_W - VAL_W){1'b0}}, want.value}, m_axis_tdata);
          if (m_axis_tuser !== want.status)
            report_mismatch("status", {{(OUT_TDATA_W - 1){1'b0}}, want.status},
                            {{(OUT_TDATA_W - 1){1'b0}}, m_axis_tuser});
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = predict_coeff(s_axis_tuser, s_axis_tdata[IDX_W-1:0],
                             s_axis_tdata[2*IDX_W-1:IDX_W]);
        if (beat_typed) want = beat_typed_result;
        expected_coeffs.push_back(want);
      end
    end
  end

  // Abort when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    directed_row_t    row;
    coeff_beat_t      typed_result;
    coeff_beat_t      no_result;
    logic [VAL_W-1:0] modulus;
    logic [IDX_W-1:0] n, k;
    int unsigned      sent, phase_len, stale_len, i;
    no_result     = '0;
    model_modulus = MODULUS_RESET;
    model_built   = 1'b0;
    foreach (coeff_model[j]) coeff_model[j] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: walk the table
    for (i = 0; i < $size(DIRECTED_ROWS); i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_MODULUS) begin
        write_modulus(row.value);
      end else begin
        typed_result.value  = row.value;
        typed_result.status = row.status;
        send_beat(row.op, row.n, row.k, row.typed, typed_result);
      end
    end

    // Random phases: new modulus, a few queries on the stale table, then a build
    // and mostly queries with an occasional rebuild.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       modulus = 30'd2;
        1:       modulus = MODULUS_MAX;
        2:       modulus = MODULUS_RESET;
        3:       modulus = VAL_W'($urandom_range(0, 1));
        4:       modulus = VAL_W'($urandom_range(3, 97));
        5:       modulus = 30'd1 << $urandom_range(1, 29);
        default: modulus = VAL_W'($urandom_range(2, 2**30 - 1));
      endcase
      write_modulus(modulus);
      phase_len = $urandom_range(60, 140);
      stale_len = $urandom_range(0, 4);
      for (i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
        n = IDX_W'($urandom_range(0, 63));
        if (i == stale_len || $urandom_range(0, 39) == 0) begin
          // index fields carry random junk on a build
          k = IDX_W'($urandom_range(0, 63));
          send_beat(OP_BUILD, n, k, 1'b0, no_result);
        end else begin
          case ($urandom_range(0, 9))
            0:       k = n;
            1:       k = 0;
            2:       k = (n < 63) ? IDX_W'($urandom_range(n + 1, 63)) : IDX_W'($urandom_range(0, 63));
            default: k = IDX_W'($urandom_range(0, n));
          endcase
          send_beat(OP_QUERY, n, k, 1'b0, no_result);
        end
        sent++;
      end
    end

    // Drain: drop valid, wait for every result, then a short tail
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_coeffs.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
